>>> rtl/core/spq_pkg.sv
package spq_pkg;

  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned CountWidth  = 5;

  typedef logic signed [ValueWidth-1:0] value_t;
  typedef logic [CountWidth-1:0]        count_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } opcode_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // Broadcast control, seen by every cell of the chain in the same cycle.
  typedef struct packed {
    logic ins_en;
    logic del_en;
  } cell_ctrl_t;

endpackage

>>> rtl/core/spq_if.sv
interface spq_cmd_if;
  import spq_pkg::*;

  logic    valid;
  logic    ready;
  opcode_e opcode;
  value_t  value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink (input valid, input opcode, input value, output ready);
endinterface

interface spq_rsp_if;
  import spq_pkg::*;

  logic    valid;
  logic    ready;
  status_e status;
  count_t  count;
  value_t  top_value;

  modport source (output valid, output status, output count, output top_value, input ready);
  modport sink (input valid, input status, input count, input top_value, output ready);
endinterface

>>> rtl/core/spq_cell.sv
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  value_t     value_i,
  input  logic       valid_i,
  input  logic       prev_ge_i,
  input  value_t     prev_entry_i,
  input  value_t     next_entry_i,
  output logic       ge_o,
  output logic       eq_o,
  output value_t     entry_o,
  output value_t     entry_d_o
);

  value_t entry_q;
  value_t entry_d;

  // An empty cell counts as lower than any value, so the flag stays monotone along the chain.
  assign ge_o = !valid_i || (value_i >= entry_q);
  assign eq_o = valid_i && (value_i == entry_q);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins_en) begin
      if (prev_ge_i) begin
        entry_d = prev_entry_i;
      end else if (ge_o) begin
        entry_d = value_i;
      end
    end else if (ctrl_i.del_en) begin
      if (ge_o) begin
        entry_d = next_entry_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o   = entry_q;
  assign entry_d_o = entry_d;

endmodule

>>> rtl/core/sorted_priority_queue_core.sv
// Priority queue of up to DEPTH signed 32-bit values kept in descending order in a
// chain of cells, one entry per cell. Each command beat (insert or delete) is
// compared against every cell at once and the chain shifts by one place in the
// same cycle, so one command is taken per clock while no pending response holds
// ready low; its response beat is in the output register the next cycle. A new
// command is taken while the previous response is still pending as long as
// that response is taken in the same cycle. Equal values are inserted ahead of
// existing ones and a delete removes the frontmost match. A full insert, an
// empty delete or a delete of an absent value leaves the contents unchanged and
// reports the matching status. The count field is reported modulo 32.
module sorted_priority_queue_core
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  spq_cmd_if.sink   cmd_i,
  spq_rsp_if.source rsp_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;
  logic            rsp_valid_q;
  status_e         status_q;
  status_e         status_d;
  count_t          count_out_q;
  value_t          top_q;
  value_t          top_d;

  logic            accept;
  logic            is_full;
  logic            is_empty;
  logic            found;
  cell_ctrl_t      ctrl;

  logic   [DEPTH-1:0] valid;
  logic   [DEPTH-1:0] ge;
  logic   [DEPTH-1:0] eq;
  value_t             entry   [DEPTH];
  value_t             entry_d [DEPTH];

  assign cmd_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = cmd_i.valid && cmd_i.ready;

  assign is_full  = (count_q == CntW'(DEPTH));
  assign is_empty = (count_q == '0);
  assign found    = |eq;

  always_comb begin
    ctrl     = '0;
    count_d  = count_q;
    status_d = ST_OK;
    unique case (cmd_i.opcode)
      OP_INSERT: begin
        if (is_full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.ins_en = accept;
          count_d     = count_q + CntW'(1);
        end
      end
      OP_DELETE: begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else if (!found) begin
          status_d = ST_NOT_FOUND;
        end else begin
          ctrl.del_en = accept;
          count_d     = count_q - CntW'(1);
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  assign top_d = (count_d == '0) ? '0 : entry_d[0];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic   prev_ge;
    value_t prev_entry;
    value_t next_entry;

    assign valid[k] = (count_q > CntW'(k));

    if (k == 0) begin : g_first
      assign prev_ge    = 1'b0;
      assign prev_entry = '0;
    end else begin : g_inner
      assign prev_ge    = ge[k-1];
      assign prev_entry = entry[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign next_entry = '0;
    end else begin : g_body
      assign next_entry = entry[k+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .value_i     (cmd_i.value),
      .valid_i     (valid[k]),
      .prev_ge_i   (prev_ge),
      .prev_entry_i(prev_entry),
      .next_entry_i(next_entry),
      .ge_o        (ge[k]),
      .eq_o        (eq[k]),
      .entry_o     (entry[k]),
      .entry_d_o   (entry_d[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      count_out_q <= count_t'(count_d);
      top_q       <= top_d;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.status    = status_q;
  assign rsp_o.count     = count_out_q;
  assign rsp_o.top_value = top_q;

endmodule
